// ----- src/ntcb_pkg.sv -----
// Package for the NTC thermistor Beta-equation converter.
// Holds widths, status codes, register indexes, pipeline stage numbers and
// the sideband struct. No dependencies.
`default_nettype none

package ntcb_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LOG_W     = 30;   // 6 integer bits, 24 fraction bits
  localparam int unsigned LOG_ARG_W = 51;   // widest log2 argument
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned DEN_W     = 42;   // signed denominator
  localparam int unsigned DIV_D_W   = 41;
  localparam int unsigned DIV_N_W   = 59;
  localparam int unsigned Q_W       = 20;

  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [19:0] KELVIN_MAX = 20'hFFFFF;

  // Stage numbers of the valid chain
  localparam int unsigned ST_LOGIN = 1;
  localparam int unsigned LOG_LAT  = 26;
  localparam int unsigned ST_MAG   = ST_LOGIN + LOG_LAT + 1;
  localparam int unsigned ST_LN    = ST_MAG + 1;
  localparam int unsigned ST_CORR  = ST_LN + 1;
  localparam int unsigned ST_DEN   = ST_CORR + 1;
  localparam int unsigned ST_NPOS  = ST_DEN + 1;
  localparam int unsigned ST_OVER  = ST_NPOS + 1;
  localparam int unsigned DIV_LAT  = 20;
  localparam int unsigned ST_OUT   = ST_OVER + DIV_LAT + 1;
  localparam int unsigned NSTG     = ST_OUT + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_ADC_BITS = 3'd0,
    REG_BETA     = 3'd1,
    REG_SERIES   = 3'd2,
    REG_NOMINAL  = 3'd3,
    REG_REF_K    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] x;
    status_t     status;
    logic        sat;      // force full-scale output
  } sb_t;

endpackage

`default_nettype wire

// ----- src/ntcb_if.sv -----
// Valid/ready channel interfaces for samples and results.
// Depends on ntcb_pkg for the status type.
`default_nettype none

interface ntcb_samp_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_reading;

  modport source (output valid, output raw_reading, input ready);
  modport sink (input valid, input raw_reading, output ready);
endinterface

interface ntcb_res_if;
  import ntcb_pkg::*;
  logic        valid;
  logic        ready;
  logic [19:0] kelvin_q8;
  logic [15:0] raw_echo;
  status_t     status;

  modport source (output valid, output kelvin_q8, output raw_echo, output status,
                  input ready);
  modport sink (input valid, input kelvin_q8, input raw_echo, input status,
                output ready);
endinterface

`default_nettype wire

// ----- src/thermistor_beta_to_kelvin.sv -----
// NTC thermistor reading to kelvin through the Beta equation.
// Depends on ntcb_pkg, ntcb_if, ntcb_log2 and ntcb_div.
//
// Usage:
//   samp carries one raw ADC reading per transaction; res returns one
//   result per transaction: kelvin_q8 (8 fraction bits), raw_echo and status
//   (ok, zero reading, reading at or above full scale, saturated).
//   The APB port sets adc_bits, beta_constant, series_ohms, nominal_ohms and
//   ref_kelvin_q8 at byte addresses 0, 4, 8, 12, 16; write only while idle.
// Timing:
//   The pipeline takes one sample per cycle while no result waits on
//   res.ready: the two 26-stage log2 squaring chains and the 20-stage
//   quotient divider each hold one sample per stage.
// Reset:
//   rst empties the pipeline and restores the register defaults.
// Stall:
//   While a result waits on res.ready the whole pipeline holds and
//   samp.ready drops; nothing is lost or repeated.
`default_nettype none

module thermistor_beta_to_kelvin (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ntcb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ntcb_pkg::DATA_W-1:0]   pwdata,
  output logic      [ntcb_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  ntcb_samp_if.sink                          samp,
  ntcb_res_if.source                         res
);
  import ntcb_pkg::*;

  // Configuration
  logic [4:0]  adc_bits;
  logic [15:0] beta_constant;
  logic [19:0] series_ohms;
  logic [19:0] nominal_ohms;
  logic [17:0] ref_kelvin_q8;
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_bits      <= 5'd10;
      beta_constant <= 16'd3975;
      series_ohms   <= 20'd10000;
      nominal_ohms  <= 20'd10000;
      ref_kelvin_q8 <= 18'd76326;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ADC_BITS: adc_bits      <= pwdata[4:0];
        REG_BETA:     beta_constant <= pwdata[15:0];
        REG_SERIES:   series_ohms   <= pwdata[19:0];
        REG_NOMINAL:  nominal_ohms  <= pwdata[19:0];
        REG_REF_K:    ref_kelvin_q8 <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ADC_BITS: prdata = DATA_W'(adc_bits);
      REG_BETA:     prdata = DATA_W'(beta_constant);
      REG_SERIES:   prdata = DATA_W'(series_ohms);
      REG_NOMINAL:  prdata = DATA_W'(nominal_ohms);
      REG_REF_K:    prdata = DATA_W'(ref_kelvin_q8);
      default:      prdata = '0;
    endcase
  end

  // Pipeline control: advance unless the output holds an untaken result
  logic [NSTG-1:0] vld;
  logic            en;

  assign en         = !vld[ST_OUT] || res.ready;
  assign samp.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], samp.valid};
    end
  end

  // Data path
  logic [15:0]          x0;
  logic [31:0]          fs;
  logic [31:0]          diff;
  status_t              st_pre;
  sb_t                  sb [ST_LOGIN:ST_OUT-1];
  logic [LOG_ARG_W-1:0] pn;
  logic [LOG_ARG_W-1:0] pd;
  logic [LOG_W-1:0]     lnum;
  logic [LOG_W-1:0]     lden;
  logic                 neg_m, neg_l, neg_c;
  logic [LOG_W-1:0]     mag;
  logic [29:0]          ln_mag;
  logic [59:0]          ln_prod;
  logic [47:0]          corr_prod;
  logic [39:0]          corr;
  logic [33:0]          bt_c, bt_d;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     den_c;
  logic                 nonpos;
  logic [DIV_D_W-1:0]   d_n, d_o;
  logic [DIV_N_W-1:0]   n_n, n_o;
  logic                 over;
  logic [Q_W-1:0]       q;
  sb_t                  sb_npos, sb_over;
  logic [19:0]          kelvin;
  logic [15:0]          echo;
  status_t              status;

  assign fs   = 32'd1 << adc_bits;
  assign diff = fs - {16'b0, x0};

  always_comb begin
    priority if (x0 == 16'd0) begin
      st_pre = ST_ZERO;
    end else if ({16'b0, x0} >= fs) begin
      st_pre = ST_RANGE;
    end else if (series_ohms == 20'd0 || nominal_ohms == 20'd0) begin
      st_pre = ST_SAT;
    end else begin
      st_pre = ST_OK;
    end
  end

  ntcb_log2 u_log_num (.clk(clk), .en(en), .v(pn), .log_q(lnum));
  ntcb_log2 u_log_den (.clk(clk), .en(en), .v(pd), .log_q(lden));

  assign ln_prod   = {30'b0, mag} * {30'b0, LN2_Q30};
  assign corr_prod = {30'b0, ref_kelvin_q8} * {18'b0, ln_mag};
  assign den_c     = neg_c ? (DEN_W'({beta_constant, 24'b0}) - DEN_W'(corr))
                           : (DEN_W'({beta_constant, 24'b0}) + DEN_W'(corr));
  assign nonpos    = den[DEN_W-1] || (den == '0);
  assign over      = ({2'b0, n_n} >= {d_n, 20'b0});

  always_comb begin
    sb_npos = sb[ST_DEN];
    if (sb[ST_DEN].status == ST_OK && nonpos) begin
      sb_npos.status = ST_SAT;
      sb_npos.sat    = 1'b1;
    end
    sb_over = sb[ST_NPOS];
    if (sb[ST_NPOS].status == ST_OK && over) begin
      sb_over.status = ST_SAT;
      sb_over.sat    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= samp.raw_reading;
      pn <= {20'b0, diff[30:0]} * {31'b0, series_ohms};
      pd <= LOG_ARG_W'({20'b0, x0} * {16'b0, nominal_ohms});
      sb[ST_LOGIN] <= '{x: x0, status: st_pre, sat: 1'b0};
      for (int i = ST_LOGIN + 1; i < ST_OUT; i++) begin
        if (i == ST_NPOS) begin
          sb[i] <= sb_npos;
        end else if (i == ST_OVER) begin
          sb[i] <= sb_over;
        end else begin
          sb[i] <= sb[i-1];
        end
      end

      // log difference, sign and magnitude
      neg_m <= lnum < lden;
      mag   <= (lnum < lden) ? (lden - lnum) : (lnum - lden);
      // natural log
      neg_l  <= neg_m;
      ln_mag <= ln_prod[59:30];
      // T0 * ln and B * T0
      neg_c <= neg_l;
      corr  <= corr_prod[47:8];
      bt_c  <= {18'b0, beta_constant} * {16'b0, ref_kelvin_q8};
      // denominator
      den  <= den_c;
      bt_d <= bt_c;
      // rounding numerator
      d_n <= den[DIV_D_W-1:0];
      n_n <= {1'b0, bt_d, 24'b0} + DIV_N_W'(den[DIV_D_W-1:1]);
      // range check
      d_o <= d_n;
      n_o <= n_n;

      // output register
      if (sb[ST_OUT-1].sat) begin
        kelvin <= KELVIN_MAX;
      end else if (sb[ST_OUT-1].status == ST_OK) begin
        kelvin <= q;
      end else begin
        kelvin <= '0;
      end
      echo   <= sb[ST_OUT-1].x;
      status <= sb[ST_OUT-1].status;
    end
  end

  ntcb_div u_div (.clk(clk), .en(en), .d(d_o), .n(n_o), .q(q));

  assign res.valid     = vld[ST_OUT];
  assign res.kelvin_q8 = kelvin;
  assign res.raw_echo  = echo;
  assign res.status    = status;

endmodule

`default_nettype wire

// ----- src/ntcb_log2.sv -----
// Pipelined log2 with 24 fraction bits: encode, normalise, then one
// squaring step per stage. Depends on ntcb_pkg.
`default_nettype none

module ntcb_log2 (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [ntcb_pkg::LOG_ARG_W-1:0]   v,
  output logic      [ntcb_pkg::LOG_W-1:0]       log_q
);
  import ntcb_pkg::*;

  logic [LOG_ARG_W-1:0] v0;
  logic [5:0]           e0;
  logic [5:0]           enc;
  logic [30:0]          norm;
  logic [30:0]          mm [0:FRAC_BITS];
  logic [5:0]           ee [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] ff [0:FRAC_BITS];
  logic [61:0]          sq [1:FRAC_BITS];

  always_comb begin
    enc = '0;
    for (int i = 0; i < LOG_ARG_W; i++) begin
      if (v[i]) enc = 6'(i);
    end
  end

  always_comb begin
    if (e0 <= 6'd30) begin
      norm = 31'(v0 << (6'd30 - e0));
    end else begin
      norm = 31'(v0 >> (e0 - 6'd30));
    end
  end

  always_comb begin
    for (int k = 1; k <= FRAC_BITS; k++) begin
      sq[k] = {31'b0, mm[k-1]} * {31'b0, mm[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0    <= v;
      e0    <= enc;
      mm[0] <= norm;
      ee[0] <= e0;
      ff[0] <= '0;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        ee[k] <= ee[k-1];
        if (sq[k][61]) begin
          mm[k] <= sq[k][61:31];
          ff[k] <= {ff[k-1][FRAC_BITS-2:0], 1'b1};
        end else begin
          mm[k] <= sq[k][60:30];
          ff[k] <= {ff[k-1][FRAC_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign log_q = {ee[FRAC_BITS], ff[FRAC_BITS]};

endmodule

`default_nettype wire

// ----- src/ntcb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for quotients
// known to fit 20 bits. Depends on ntcb_pkg.
`default_nettype none

module ntcb_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ntcb_pkg::DIV_D_W-1:0]  d,
  input  wire logic [ntcb_pkg::DIV_N_W-1:0]  n,
  output logic      [ntcb_pkg::Q_W-1:0]      q
);
  import ntcb_pkg::*;

  localparam int unsigned CMP_W = DIV_D_W + Q_W + 1;

  logic [DIV_N_W-1:0] rem [0:Q_W-1];
  logic [DIV_D_W-1:0] dd  [0:Q_W-1];
  logic [Q_W-1:0]     qq  [0:Q_W-1];
  logic [CMP_W-1:0]   trial [0:Q_W-1];
  logic [CMP_W-1:0]   rin   [0:Q_W-1];

  always_comb begin
    trial[0] = CMP_W'({d, 19'b0});
    rin[0]   = CMP_W'(n);
    for (int k = 1; k < Q_W; k++) begin
      trial[k] = CMP_W'(dd[k-1]) << (Q_W - 1 - k);
      rin[k]   = CMP_W'(rem[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= d;
      if (rin[0] >= trial[0]) begin
        rem[0] <= DIV_N_W'(rin[0] - trial[0]);
        qq[0]  <= Q_W'(1);
      end else begin
        rem[0] <= DIV_N_W'(rin[0]);
        qq[0]  <= Q_W'(0);
      end
      for (int k = 1; k < Q_W; k++) begin
        dd[k] <= dd[k-1];
        if (rin[k] >= trial[k]) begin
          rem[k] <= DIV_N_W'(rin[k] - trial[k]);
          qq[k]  <= {qq[k-1][Q_W-2:0], 1'b1};
        end else begin
          rem[k] <= DIV_N_W'(rin[k]);
          qq[k]  <= {qq[k-1][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q = qq[Q_W-1];

endmodule

`default_nettype wire
